// ----- rtl/core/sha1hs_pkg.sv -----
// ----------------------------------------------------------------------------
// sha1hs_pkg
// Shared types and constants for the SHA-1 byte stream hasher.
// ----------------------------------------------------------------------------
package sha1hs_pkg;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [6:0] LAST_RND = 7'd79;
  localparam logic [2:0] LAST_IDX = 3'd4;

  // one queued command from the front end
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eom;
  } cmd_t;

  // digest handoff between engine and output stage
  typedef struct packed {
    logic        load;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    logic [31:0] w4;
  } dig_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PAD   = 4'b0010,
    S_ROUND = 4'b0100,
    S_ADD   = 4'b1000
  } eng_state_t;

endpackage

// ----- rtl/core/sha1hs_front.sv -----
// ----------------------------------------------------------------------------
// sha1hs_front
// Accepts input items, drops empty ones and queues commands for the engine.
// ----------------------------------------------------------------------------
module sha1hs_front import sha1hs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       msg_valid,
  output logic       msg_stall,
  input  logic [7:0] data_byte,
  input  logic       has_byte,
  input  logic       end_of_message,
  output logic       q_valid,
  output cmd_t       q_head,
  input  logic       q_pop
);

  cmd_t       mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       push;
  logic       keep;

  assign msg_stall = (count == 3'd4);
  // an item with neither byte nor end does nothing
  assign keep      = has_byte | end_of_message;
  assign push      = msg_valid & ~msg_stall & keep;
  assign q_valid   = (count != 3'd0);
  assign q_head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{data: data_byte, has_byte: has_byte, eom: end_of_message};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (q_pop) rd_ptr <= rd_ptr + 2'd1;
      unique case ({push, q_pop})
        2'b10:   count <= count + 3'd1;
        2'b01:   count <= count - 3'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/sha1hs_engine.sv -----
// ----------------------------------------------------------------------------
// sha1hs_engine
// Block assembly, padding and the 80-round compression, one round a cycle.
// ----------------------------------------------------------------------------
module sha1hs_engine import sha1hs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  cmd_t q_head,
  output logic q_pop,
  input  logic out_free,
  output dig_t dig
);

  eng_state_t  state;
  logic [31:0] w [16];
  logic [23:0] acc;
  logic [5:0]  fill;
  logic [63:0] msg_bits;
  logic [63:0] len;
  logic        pad_first;
  logic        len_phase;
  logic        pad_active;
  logic        final_blk;
  logic [6:0]  rnd;
  logic [31:0] a, b, c, d, e;
  logic [31:0] chain [5];

  logic        put_en;
  logic [7:0]  put_val;
  logic        wrap;
  logic [7:0]  len_byte;
  logic [31:0] f, k, t, w_new, x;

  assign q_pop    = (state == S_IDLE) & q_valid;
  assign len_byte = len[{~fill[2:0], 3'b000} +: 8];

  always_comb begin
    put_en  = 1'b0;
    put_val = q_head.data;
    priority if (state == S_IDLE) begin
      put_en = q_pop & q_head.has_byte;
    end else if (state == S_PAD) begin
      put_en = 1'b1;
      priority if (pad_first)                   put_val = PAD_BYTE;
      else if (len_phase || (fill == LEN_POS))  put_val = len_byte;
      else                                      put_val = 8'h00;
    end
  end

  assign wrap = put_en & (fill == 6'd63);

  always_comb begin
    priority if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);          k = K0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;                   k = K1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d); k = K2;
    end else begin
      f = b ^ c ^ d;                   k = K3;
    end
  end

  assign t     = {a[26:0], a[31:27]} + f + e + k + w[0];
  assign x     = w[13] ^ w[8] ^ w[2] ^ w[0];
  assign w_new = {x[30:0], x[31]};

  assign dig.load = (state == S_ADD) & final_blk & out_free;
  assign dig.w0   = chain[0] + a;
  assign dig.w1   = chain[1] + b;
  assign dig.w2   = chain[2] + c;
  assign dig.w3   = chain[3] + d;
  assign dig.w4   = chain[4] + e;

  // schedule window: w[0] is the word for the current round
  always_ff @(posedge clk) begin
    if (put_en) begin
      acc <= {acc[15:0], put_val};
      if (fill[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= {acc, put_val};
      end
    end else if (state == S_ROUND) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      msg_bits   <= '0;
      pad_first  <= 1'b0;
      len_phase  <= 1'b0;
      pad_active <= 1'b0;
      final_blk  <= 1'b0;
      rnd        <= '0;
      chain      <= '{H0, H1, H2, H3, H4};
    end else begin
      if (put_en) fill <= fill + 6'd1;
      if (wrap) begin
        rnd <= '0;
        a <= chain[0]; b <= chain[1]; c <= chain[2]; d <= chain[3]; e <= chain[4];
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (q_head.has_byte) msg_bits <= msg_bits + 64'd8;
            if (q_head.eom) begin
              len        <= msg_bits + (q_head.has_byte ? 64'd8 : 64'd0);
              pad_active <= 1'b1;
              pad_first  <= 1'b1;
              len_phase  <= 1'b0;
            end
            priority if (wrap)    state <= S_ROUND;
            else if (q_head.eom)  state <= S_PAD;
          end
        end
        S_PAD: begin
          pad_first <= 1'b0;
          if (!pad_first && fill == LEN_POS) len_phase <= 1'b1;
          if (wrap) begin
            final_blk <= len_phase;
            state     <= S_ROUND;
          end
        end
        S_ROUND: begin
          e <= d;
          d <= c;
          c <= {b[1:0], b[31:2]};
          b <= a;
          a <= t;
          rnd <= rnd + 7'd1;
          if (rnd == LAST_RND) state <= S_ADD;
        end
        S_ADD: begin
          if (!final_blk) begin
            chain <= '{dig.w0, dig.w1, dig.w2, dig.w3, dig.w4};
            state <= pad_active ? S_PAD : S_IDLE;
          end else if (out_free) begin
            chain      <= '{H0, H1, H2, H3, H4};
            msg_bits   <= '0;
            pad_active <= 1'b0;
            final_blk  <= 1'b0;
            len_phase  <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/sha1_hash_stream.sv -----
// ----------------------------------------------------------------------------
// sha1_hash_stream
// SHA-1 over a byte stream; emits the digest as five 32-bit words.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  msg     | msg_valid/msg_stall  | data_byte, has_byte, end_of_message
//  dig     | dig_valid/dig_stall  | digest_word, word_index, last_word
//
//  The engine takes bytes only while idle; a full block runs 80 rounds in
//  the single round unit plus the chaining add. End of message pads one byte
//  a cycle, pausing while a block compresses, and compresses one or two
//  blocks. A four-entry command queue lets input run ahead of the engine.
//  Reset is synchronous and clears all control. Digest words leave from a
//  shift register; a held digest stalls the engine only when the next is ready.
module sha1_hash_stream import sha1hs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        dig_valid,
  input  logic        dig_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  logic        q_valid;
  cmd_t        q_head;
  logic        q_pop;
  dig_t        dig;
  logic        busy;
  logic [2:0]  idx;
  logic [31:0] dsh [5];

  sha1hs_front u_front (
    .clk, .rst, .msg_valid, .msg_stall, .data_byte, .has_byte, .end_of_message,
    .q_valid, .q_head, .q_pop
  );

  sha1hs_engine u_engine (
    .clk, .rst, .q_valid, .q_head, .q_pop, .out_free(~busy), .dig
  );

  assign dig_valid   = busy;
  assign digest_word = dsh[0];
  assign word_index  = idx;
  assign last_word   = (idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (dig.load) begin
      dsh <= '{dig.w0, dig.w1, dig.w2, dig.w3, dig.w4};
    end else if (busy && !dig_stall) begin
      for (int i = 0; i < 4; i++) dsh[i] <= dsh[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (dig.load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && !dig_stall) begin
      idx <= idx + 3'd1;
      if (idx == LAST_IDX) busy <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/sha1hs_checker.sv -----
// ----------------------------------------------------------------------------
// sha1hs_checker
// Port-level checks on the digest channel of sha1_hash_stream.
// ----------------------------------------------------------------------------
module sha1hs_checker (
  input logic        clk,
  input logic        rst,
  input logic        dig_valid,
  input logic        dig_stall,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> (last_word == (word_index == 3'd4)))
    else $error("last_word does not match word_index");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> (word_index <= 3'd4))
    else $error("word_index out of range");

  a_words_follow: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && !dig_stall && !last_word) |=>
      (dig_valid && word_index == $past(word_index) + 3'd1))
    else $error("digest transaction sequence broken");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && dig_stall) |=>
      (dig_valid && $stable(digest_word) && $stable(word_index)))
    else $error("stalled digest word changed");

endmodule

bind sha1_hash_stream sha1hs_checker u_checker (
  .clk, .rst, .dig_valid, .dig_stall, .digest_word, .word_index, .last_word
);
